/* rtl/ttcb_pkg.sv */
// ----------------------------------------------------------------------------
// ttcb_pkg
// Shared constants, codes and the put-byte step decoder of the character grid.
// ----------------------------------------------------------------------------
package ttcb_pkg;

  localparam int COLS_DEF = 60;
  localparam int ROWS_DEF = 15;

  localparam int MODE_W = 2;
  localparam int CHAR_W = 8;
  localparam int ROW_FW = 4;
  localparam int COL_FW = 6;

  typedef enum logic [MODE_W-1:0] {
    MODE_PUT   = 2'd0,
    MODE_READ  = 2'd1,
    MODE_CLEAR = 2'd2,
    MODE_NONE  = 2'd3
  } mode_e;

  localparam logic [CHAR_W-1:0] CH_ETX   = 8'h03;
  localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_ESC   = 8'h1B;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_CARET = 8'h5E;
  localparam logic [CHAR_W-1:0] CH_BLANK = 8'h00;
  localparam logic [5*CHAR_W-1:0] CTLC_STR = "Ctl-C";

  localparam int STEP_W = 3;

  typedef enum logic [1:0] {
    OP_WR,
    OP_CLR,
    OP_LF,
    OP_END
  } op_e;

  typedef struct packed {
    op_e               op;
    logic [CHAR_W-1:0] ch;
  } step_t;

  function automatic step_t put_step(input logic [CHAR_W-1:0] c, input logic [STEP_W-1:0] k);
    step_t s;
    s.op = OP_END;
    s.ch = CH_BLANK;
    case (c)
      CH_CR: begin
        s.op = OP_END;
      end
      CH_LF: begin
        if (k == 3'd0 || k == 3'd2) s.op = OP_CLR;
        else if (k == 3'd1) s.op = OP_LF;
      end
      CH_TAB: begin
        if (k < 3'd4) begin
          s.op = OP_WR;
          s.ch = CH_SPACE;
        end else if (k == 3'd4) begin
          s.op = OP_CLR;
        end
      end
      CH_BS: begin
        if (k < 3'd2) s.op = OP_CLR;
      end
      CH_ESC: begin
        if (k == 3'd0) begin
          s.op = OP_WR;
          s.ch = CH_CARET;
        end else if (k == 3'd1) begin
          s.op = OP_CLR;
        end
      end
      CH_ETX: begin
        if (k < 3'd5) begin
          s.op = OP_WR;
          s.ch = CTLC_STR[CHAR_W*(4-int'(k)) +: CHAR_W];
        end else if (k == 3'd5) begin
          s.op = OP_CLR;
        end
      end
      default: begin
        if (k == 3'd0) begin
          s.op = OP_WR;
          s.ch = c;
        end else if (k == 3'd1) begin
          s.op = OP_CLR;
        end
      end
    endcase
    return s;
  endfunction

endpackage

/* rtl/ttcb_if.sv */
// ----------------------------------------------------------------------------
// ttcb_if
// Valid/ready channels for request words and result words.
// ----------------------------------------------------------------------------
interface ttcb_in_if;
  logic                           valid;
  logic                           ready;
  logic [ttcb_pkg::MODE_W-1:0]    mode;
  logic [ttcb_pkg::CHAR_W-1:0]    char_in;
  logic [ttcb_pkg::ROW_FW-1:0]    read_row;
  logic [ttcb_pkg::COL_FW-1:0]    read_col;

  modport source (output valid, mode, char_in, read_row, read_col, input ready);
  modport sink   (input valid, mode, char_in, read_row, read_col, output ready);
endinterface

interface ttcb_out_if;
  logic                           valid;
  logic                           ready;
  logic [ttcb_pkg::CHAR_W-1:0]    cell_char;
  logic [ttcb_pkg::ROW_FW-1:0]    cursor_row;
  logic [ttcb_pkg::COL_FW-1:0]    cursor_col;
  logic                           scrolled;

  modport source (output valid, cell_char, cursor_row, cursor_col, scrolled, input ready);
  modport sink   (input valid, cell_char, cursor_row, cursor_col, scrolled, output ready);
endinterface

/* rtl/ttcb_grid_mem.sv */
// ----------------------------------------------------------------------------
// ttcb_grid_mem
// Character cell store, one write port and one registered read port.
// ----------------------------------------------------------------------------
module ttcb_grid_mem import ttcb_pkg::*; #(
  parameter int DEPTH = ROWS_DEF * COLS_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [AW-1:0]     waddr_i,
  input  logic [CHAR_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [AW-1:0]     raddr_i,
  output logic [CHAR_W-1:0] rdata_o
);

  logic [CHAR_W-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
  end

  always_ff @(posedge clk_i) begin
    if (re_i) rdata_o <= mem[raddr_i];
  end

endmodule

/* rtl/ttcb_seq.sv */
// ----------------------------------------------------------------------------
// ttcb_seq
// Request sequencer: cursor, row ring, row valid bits and result register.
// ----------------------------------------------------------------------------
module ttcb_seq import ttcb_pkg::*; #(
  parameter int COLS = COLS_DEF,
  parameter int ROWS = ROWS_DEF,
  parameter int CW   = $clog2(COLS),
  parameter int RW   = $clog2(ROWS),
  parameter int AW   = $clog2(ROWS * COLS)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  ttcb_in_if.sink           in_i,
  ttcb_out_if.source        out_o,
  output logic              mem_we_o,
  output logic [AW-1:0]     mem_waddr_o,
  output logic [CHAR_W-1:0] mem_wdata_o,
  output logic              mem_re_o,
  output logic [AW-1:0]     mem_raddr_o,
  input  logic [CHAR_W-1:0] mem_rdata_i
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PUT,
    ST_SWEEP,
    ST_RADDR,
    ST_RDATA,
    ST_DONE
  } state_e;

  state_e              state_q;
  logic [CHAR_W-1:0]   char_q;
  logic [ROW_FW-1:0]   rrow_q;
  logic [COL_FW-1:0]   rcol_q;
  logic [STEP_W-1:0]   step_q;
  logic [RW-1:0]       row_q;
  logic [CW-1:0]       col_q;
  logic [RW-1:0]       base_q;
  logic [ROWS-1:0]     valid_q;
  logic [CW-1:0]       sweep_q;
  logic                scrolled_q;
  logic                hit_q;
  logic [CHAR_W-1:0]   cell_q;
  logic                out_valid_q;
  logic [CHAR_W-1:0]   out_char_q;
  logic [ROW_FW-1:0]   out_row_q;
  logic [COL_FW-1:0]   out_col_q;
  logic                out_scr_q;

  logic [RW:0]         cur_sum;
  logic [RW-1:0]       cur_phys;
  logic [RW:0]         rd_sum;
  logic [RW-1:0]       rd_phys;
  logic                rd_in_range;
  step_t               step;
  logic [CHAR_W-1:0]   wval;
  logic                cur_valid;
  logic                col_last;
  logic                row_last;
  logic [RW-1:0]       base_next;
  logic [CW-1:0]       wcol;
  logic                put_wr;

  assign cur_sum  = {1'b0, row_q} + {1'b0, base_q};
  assign cur_phys = (cur_sum >= (RW+1)'(ROWS)) ? RW'(cur_sum - (RW+1)'(ROWS)) : cur_sum[RW-1:0];
  assign rd_sum   = (RW+1)'(rrow_q) + {1'b0, base_q};
  assign rd_phys  = (rd_sum >= (RW+1)'(ROWS)) ? RW'(rd_sum - (RW+1)'(ROWS)) : rd_sum[RW-1:0];
  assign rd_in_range = (rrow_q < ROWS) && (rcol_q < COLS);

  assign step      = put_step(char_q, step_q);
  assign wval      = (step.op == OP_WR) ? step.ch : CH_BLANK;
  assign cur_valid = valid_q[cur_phys];
  assign col_last  = (col_q == CW'(COLS - 1));
  assign row_last  = (row_q == RW'(ROWS - 1));
  assign base_next = (base_q == RW'(ROWS - 1)) ? '0 : base_q + 1'b1;

  assign put_wr = (state_q == ST_PUT) && (step.op == OP_WR || step.op == OP_CLR) && cur_valid;
  assign wcol   = (state_q == ST_SWEEP) ? sweep_q : col_q;

  assign mem_we_o    = put_wr || (state_q == ST_SWEEP);
  assign mem_waddr_o = AW'(cur_phys) * AW'(COLS) + AW'(wcol);
  assign mem_wdata_o = (state_q == ST_SWEEP) ? CH_BLANK : wval;
  assign mem_re_o    = (state_q == ST_RADDR) && rd_in_range;
  assign mem_raddr_o = AW'(rd_phys) * AW'(COLS) + AW'(rcol_q);

  assign in_i.ready       = (state_q == ST_IDLE);
  assign out_o.valid      = out_valid_q;
  assign out_o.cell_char  = out_char_q;
  assign out_o.cursor_row = out_row_q;
  assign out_o.cursor_col = out_col_q;
  assign out_o.scrolled   = out_scr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      row_q       <= '0;
      col_q       <= '0;
      base_q      <= '0;
      valid_q     <= '0;
      sweep_q     <= '0;
      scrolled_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_o.ready && state_q != ST_DONE) out_valid_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (in_i.valid) begin
            char_q     <= in_i.char_in;
            rrow_q     <= in_i.read_row;
            rcol_q     <= in_i.read_col;
            scrolled_q <= 1'b0;
            cell_q     <= CH_BLANK;
            step_q     <= '0;
            case (mode_e'(in_i.mode))
              MODE_PUT:  state_q <= ST_PUT;
              MODE_READ: state_q <= ST_RADDR;
              MODE_CLEAR: begin
                valid_q <= '0;
                row_q   <= '0;
                col_q   <= '0;
                state_q <= ST_DONE;
              end
              default:   state_q <= ST_DONE;
            endcase
          end
        end
        ST_PUT: begin
          case (step.op)
            OP_WR, OP_CLR: begin
              if (!cur_valid && wval != CH_BLANK) begin
                sweep_q <= '0;
                state_q <= ST_SWEEP;
              end else begin
                step_q <= step_q + 1'b1;
                if (step.op == OP_WR) begin
                  if (col_last) begin
                    col_q <= '0;
                    if (row_last) begin
                      base_q          <= base_next;
                      valid_q[base_q] <= 1'b0;
                      scrolled_q      <= 1'b1;
                    end else begin
                      row_q <= row_q + 1'b1;
                    end
                  end else begin
                    col_q <= col_q + 1'b1;
                  end
                end
              end
            end
            OP_LF: begin
              step_q <= step_q + 1'b1;
              col_q  <= '0;
              if (row_last) begin
                base_q          <= base_next;
                valid_q[base_q] <= 1'b0;
                scrolled_q      <= 1'b1;
              end else begin
                row_q <= row_q + 1'b1;
              end
            end
            default: state_q <= ST_DONE;
          endcase
        end
        ST_SWEEP: begin
          if (sweep_q == CW'(COLS - 1)) begin
            valid_q[cur_phys] <= 1'b1;
            state_q           <= ST_PUT;
          end else begin
            sweep_q <= sweep_q + 1'b1;
          end
        end
        ST_RADDR: begin
          hit_q   <= rd_in_range && valid_q[rd_phys];
          state_q <= ST_RDATA;
        end
        ST_RDATA: begin
          cell_q  <= hit_q ? mem_rdata_i : CH_BLANK;
          state_q <= ST_DONE;
        end
        ST_DONE: begin
          if (!out_valid_q || out_o.ready) begin
            out_valid_q <= 1'b1;
            out_char_q  <= cell_q;
            out_row_q   <= ROW_FW'(row_q);
            out_col_q   <= COL_FW'(col_q);
            out_scr_q   <= scrolled_q;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

/* rtl/text_terminal_char_buffer.sv */
// ----------------------------------------------------------------------------
// text_terminal_char_buffer
// Character grid of a dumb terminal with a linear cursor.
// ----------------------------------------------------------------------------
// Requests enter on in_i (put byte, read cell, clear) and each one gives
// exactly one result word on out_o: the cell read, the cursor after the
// request and a scroll flag. One request is worked on at a time.
// A put occupies the block for each of its steps, the closing step included,
// and then for the result register; a read passes an address state and a
// data state, and a clear or an unused mode goes straight to the result
// register. The result word appears in the cycle in which in_i is ready again.
// The first non-blank write into a blank row first sweeps that row to blanks.
// Scrolling advances a row ring and drops the old top row's valid bit, so it
// needs no memory pass; a clear drops all row valid bits at once.
// Reset clears the cursor, ring and valid bits at once; no memory pass runs.
// When out_o stalls, the finished word waits in the output register while
// the next request is taken; its result then waits until the slot frees.
// ----------------------------------------------------------------------------
module text_terminal_char_buffer import ttcb_pkg::*; #(
  parameter int COLS = COLS_DEF,
  parameter int ROWS = ROWS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  ttcb_in_if.sink     in_i,
  ttcb_out_if.source  out_o
);

  localparam int CW    = $clog2(COLS);
  localparam int RW    = $clog2(ROWS);
  localparam int DEPTH = ROWS * COLS;
  localparam int AW    = $clog2(DEPTH);

  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [CHAR_W-1:0] mem_wdata;
  logic              mem_re;
  logic [AW-1:0]     mem_raddr;
  logic [CHAR_W-1:0] mem_rdata;

  ttcb_seq #(
    .COLS (COLS),
    .ROWS (ROWS),
    .CW   (CW),
    .RW   (RW),
    .AW   (AW)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .out_o       (out_o),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  ttcb_grid_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_grid_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

endmodule

/* rtl/ttcb_checker.sv */
// ----------------------------------------------------------------------------
// ttcb_checker
// Port-level checks of the character grid, bound to the top level.
// ----------------------------------------------------------------------------
module ttcb_checker import ttcb_pkg::*; #(
  parameter int COLS = COLS_DEF,
  parameter int ROWS = ROWS_DEF
) (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_i,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input logic [CHAR_W-1:0] cell_char_i,
  input logic [ROW_FW-1:0] cursor_row_i,
  input logic [COL_FW-1:0] cursor_col_i,
  input logic              scrolled_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(cell_char_i)
      && $stable(cursor_row_i) && $stable(cursor_col_i) && $stable(scrolled_i))
    else $error("result word changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("request taken while another is in work");

  a_cursor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (cursor_row_i < ROWS) && (cursor_col_i < COLS))
    else $error("cursor outside the grid");

  a_scroll_last_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && scrolled_i |-> cursor_row_i == ROW_FW'(ROWS - 1)
      && cell_char_i == CH_BLANK)
    else $error("scrolled result not on the last row");

endmodule

bind text_terminal_char_buffer ttcb_checker #(
  .COLS (COLS),
  .ROWS (ROWS)
) u_ttcb_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .cell_char_i  (out_o.cell_char),
  .cursor_row_i (out_o.cursor_row),
  .cursor_col_i (out_o.cursor_col),
  .scrolled_i   (out_o.scrolled)
);

/* verif/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the terminal character grid. A queue of requests
// (directed, then three random phases) feeds a bursty valid/ready driver; a
// monitor with its own stall pattern checks every result word against a
// cycle-free model of the grid and cursor kept alongside the block.
// ----------------------------------------------------------------------------
module testbench;
  import ttcb_pkg::*;

  localparam int NCOLS          = COLS_DEF;
  localparam int NROWS          = ROWS_DEF;
  localparam int NCELLS         = NCOLS * NROWS;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int LONG_HOLD      = 250;
  localparam int TAIL_CYCLES    = 100;

  typedef struct {
    mode_e             mode;
    logic [CHAR_W-1:0] ch;
    logic [ROW_FW-1:0] row;
    logic [COL_FW-1:0] col;
    bit                drain;
  } req_t;

  typedef struct packed {
    logic [CHAR_W-1:0] glyph;
    logic [ROW_FW-1:0] row;
    logic [COL_FW-1:0] col;
    logic              scrolled;
  } report_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  ttcb_in_if  in_if ();
  ttcb_out_if out_if ();

  text_terminal_char_buffer dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  logic [CHAR_W-1:0] screen [NCELLS];
  int unsigned       cursor;
  bit                scroll_hit;

  req_t    request_q [$];
  report_t report_q [$];

  int n_put, n_read, n_clear, n_none, n_results, n_scrolls, n_fail;

  function automatic void scroll_screen();
    for (int i = 0; i < NCELLS - NCOLS; i++) screen[i] = screen[i + NCOLS];
    for (int i = NCELLS - NCOLS; i < NCELLS; i++) screen[i] = CH_BLANK;
    cursor = NCELLS - NCOLS;
    scroll_hit = 1'b1;
  endfunction

  function automatic void write_glyph(input logic [CHAR_W-1:0] c);
    screen[cursor] = c;
    cursor++;
    if (cursor >= NCELLS) scroll_screen();
  endfunction

  function automatic void put_char(input logic [CHAR_W-1:0] c);
    if (c == CH_CR) return;
    case (c)
      CH_LF: begin
        screen[cursor] = CH_BLANK;
        if (cursor / NCOLS + 1 >= NROWS) scroll_screen();
        else cursor = (cursor / NCOLS + 1) * NCOLS;
      end
      CH_TAB: repeat (4) write_glyph(CH_SPACE);
      CH_BS: screen[cursor] = CH_BLANK;
      CH_ESC: write_glyph(CH_CARET);
      CH_ETX: for (int k = 0; k < 5; k++) write_glyph(CTLC_STR[CHAR_W*(4-k) +: CHAR_W]);
      default: write_glyph(c);
    endcase
    screen[cursor] = CH_BLANK;
  endfunction

  function automatic report_t apply_request(input mode_e m, input logic [CHAR_W-1:0] c,
                                            input logic [ROW_FW-1:0] r,
                                            input logic [COL_FW-1:0] k);
    report_t rep;
    rep = '0;
    scroll_hit = 1'b0;
    case (m)
      MODE_PUT: put_char(c);
      MODE_READ: if (r < NROWS && k < NCOLS) rep.glyph = screen[int'(r) * NCOLS + int'(k)];
      MODE_CLEAR: begin
        foreach (screen[i]) screen[i] = CH_BLANK;
        cursor = 0;
      end
      default: ;
    endcase
    rep.row = ROW_FW'(cursor / NCOLS);
    rep.col = COL_FW'(cursor % NCOLS);
    rep.scrolled = scroll_hit;
    return rep;
  endfunction

  function automatic void push_req(input mode_e m, input logic [CHAR_W-1:0] c,
                                   input logic [ROW_FW-1:0] r, input logic [COL_FW-1:0] k,
                                   input bit drain);
    req_t q;
    q.mode = m;
    q.ch = c;
    q.row = r;
    q.col = k;
    q.drain = drain;
    request_q.push_back(q);
  endfunction

  // style 0: line-feed rich text, 1: long text without line feeds, 2: any byte
  function automatic logic [CHAR_W-1:0] pick_byte(input int style);
    int unsigned w;
    logic [CHAR_W-1:0] specials [5];
    logic [CHAR_W-1:0] b;
    specials = '{CH_CR, CH_TAB, CH_BS, CH_ESC, CH_ETX};
    w = $urandom_range(99, 0);
    if (style == 2) return CHAR_W'($urandom_range(255, 0));
    if (style == 0 && w < 12) return CH_LF;
    if (w < 20) return specials[$urandom_range(4, 0)];
    if (w < 88) return CHAR_W'($urandom_range(126, 32));
    b = CHAR_W'($urandom_range(255, 0));
    if (style == 1 && b == CH_LF) b = CHAR_W'("x");
    return b;
  endfunction

  function automatic void push_read(input bit anywhere, input bit drain);
    if (anywhere || $urandom_range(9, 0) == 0)
      push_req(MODE_READ, CHAR_W'($urandom_range(255, 0)), ROW_FW'($urandom_range(15, 0)),
               COL_FW'($urandom_range(63, 0)), drain);
    else
      push_req(MODE_READ, CHAR_W'($urandom_range(255, 0)),
               ROW_FW'($urandom_range(NROWS - 1, 0)), COL_FW'($urandom_range(NCOLS - 1, 0)),
               drain);
  endfunction

  function automatic void push_random(input int style, input bit drain);
    int unsigned w;
    w = $urandom_range(999, 0);
    if (style == 2) begin
      if (w < 500) push_req(MODE_PUT, pick_byte(2), ROW_FW'($urandom_range(15, 0)),
                            COL_FW'($urandom_range(63, 0)), drain);
      else if (w < 880) push_read(1'b1, drain);
      else if (w < 990) push_req(mode_e'(MODE_NONE), CHAR_W'($urandom_range(255, 0)),
                                 ROW_FW'($urandom_range(15, 0)),
                                 COL_FW'($urandom_range(63, 0)), drain);
      else push_req(MODE_CLEAR, CHAR_W'($urandom_range(255, 0)),
                    ROW_FW'($urandom_range(15, 0)), COL_FW'($urandom_range(63, 0)), drain);
    end else if (style == 1) begin
      if (w < 800) push_req(MODE_PUT, pick_byte(1), '0, '0, drain);
      else push_read(1'b0, drain);
    end else begin
      if (w < 616) push_req(MODE_PUT, pick_byte(0), '0, '0, drain);
      else if (w < 976) push_read(1'b0, drain);
      else if (w < 996) push_req(MODE_NONE, CHAR_W'($urandom_range(255, 0)),
                                 ROW_FW'($urandom_range(15, 0)),
                                 COL_FW'($urandom_range(63, 0)), drain);
      else push_req(MODE_CLEAR, '0, '0, '0, drain);
    end
  endfunction

  // driver: bursts of random length with random gaps
  int  burst_left, gap_left;
  req_t nxt;
  report_t want;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid    <= 1'b0;
      in_if.mode     <= MODE_PUT;
      in_if.char_in  <= '0;
      in_if.read_row <= '0;
      in_if.read_col <= '0;
      burst_left = 0;
      gap_left = 0;
      foreach (screen[i]) screen[i] = CH_BLANK;
      cursor = 0;
    end else if (!in_if.valid || in_if.ready) begin
      if (in_if.valid) begin
        report_q.push_back(apply_request(mode_e'(in_if.mode), in_if.char_in,
                                         in_if.read_row, in_if.read_col));
        case (mode_e'(in_if.mode))
          MODE_PUT:   n_put++;
          MODE_READ:  n_read++;
          MODE_CLEAR: n_clear++;
          default:    n_none++;
        endcase
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          if ($urandom_range(9, 0) == 0) begin
            burst_left = 80;
            gap_left = 0;
          end else begin
            burst_left = $urandom_range(30, 1);
            gap_left = ($urandom_range(5, 0) == 0) ? 0 : $urandom_range(6, 1);
          end
        end
      end
      if (gap_left > 0) begin
        gap_left--;
        in_if.valid <= 1'b0;
      end else if (request_q.size() != 0 &&
                   !(request_q[0].drain && report_q.size() != 0)) begin
        nxt = request_q.pop_front();
        in_if.mode     <= nxt.mode;
        in_if.char_in  <= nxt.ch;
        in_if.read_row <= nxt.row;
        in_if.read_col <= nxt.col;
        in_if.valid    <= 1'b1;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // monitor: checks results, stalls on a pattern of its own
  int  hold_left, last_hold_at, stall_style, rx_cycle;
  logic [6:0] stall_pat;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      hold_left = 0;
      last_hold_at = -1;
      stall_style = 0;
      rx_cycle = 0;
      stall_pat = 7'b1011001;
    end else begin
      if (out_if.valid && out_if.ready) begin
        n_results++;
        if (report_q.size() == 0) begin
          $error("result word with no request outstanding");
          n_fail++;
        end else begin
          want = report_q.pop_front();
          if (want.scrolled) n_scrolls++;
          if (out_if.cell_char !== want.glyph) begin
            $error("cell_char: expected %0h, got %0h", want.glyph, out_if.cell_char);
            n_fail++;
          end
          if (out_if.cursor_row !== want.row) begin
            $error("cursor_row: expected %0d, got %0d", want.row, out_if.cursor_row);
            n_fail++;
          end
          if (out_if.cursor_col !== want.col) begin
            $error("cursor_col: expected %0d, got %0d", want.col, out_if.cursor_col);
            n_fail++;
          end
          if (out_if.scrolled !== want.scrolled) begin
            $error("scrolled: expected %0b, got %0b", want.scrolled, out_if.scrolled);
            n_fail++;
          end
        end
      end
      rx_cycle++;
      if (rx_cycle % 97 == 0) stall_style = $urandom_range(2, 0);
      if ((n_results == 100 || n_results == 800) && last_hold_at != n_results) begin
        last_hold_at = n_results;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        case (stall_style)
          0:       out_if.ready <= 1'b1;
          1:       out_if.ready <= stall_pat[rx_cycle % 7];
          default: out_if.ready <= ($urandom_range(2, 0) != 0);
        endcase
      end
    end
  end

  int idle_cycles;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin
    // two grid corners, reads off the grid, every special byte, unused mode, clear
    push_req(MODE_READ, '0, 4'd0, 6'd0, 1'b0);
    push_req(MODE_READ, '0, 4'd14, 6'd59, 1'b0);
    push_req(MODE_READ, 8'hFF, 4'd15, 6'd63, 1'b0);
    push_req(MODE_READ, '0, 4'd0, 6'd60, 1'b0);
    push_req(MODE_PUT, 8'h41, '0, '0, 1'b0);
    push_req(MODE_PUT, 8'h00, '0, '0, 1'b0);
    push_req(MODE_PUT, 8'hFF, '0, '0, 1'b0);
    push_req(MODE_PUT, CH_CR, '0, '0, 1'b0);
    push_req(MODE_PUT, CH_TAB, '0, '0, 1'b0);
    push_req(MODE_PUT, CH_ETX, '0, '0, 1'b0);
    push_req(MODE_PUT, CH_ESC, '0, '0, 1'b0);
    push_req(MODE_PUT, CH_BS, '0, '0, 1'b0);
    push_req(MODE_READ, '0, 4'd0, 6'd0, 1'b0);
    push_req(MODE_READ, '0, 4'd0, 6'd2, 1'b0);
    push_req(MODE_READ, '0, 4'd0, 6'd3, 1'b0);
    push_req(MODE_READ, '0, 4'd0, 6'd8, 1'b0);
    push_req(MODE_PUT, CH_LF, '0, '0, 1'b0);
    push_req(MODE_NONE, 8'hFF, 4'd15, 6'd63, 1'b0);
    push_req(MODE_CLEAR, 8'hFF, 4'd15, 6'd63, 1'b0);
    push_req(MODE_READ, '0, 4'd0, 6'd0, 1'b0);
    push_req(MODE_PUT, CH_LF, '0, '0, 1'b0);

    for (int i = 0; i < 500; i++) push_random(0, i == 0);
    for (int i = 0; i < 400; i++) push_random(1, i == 0);
    for (int i = 0; i < 400; i++) push_random(2, i == 0);

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (request_q.size() != 0 || in_if.valid || report_q.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Covered %0d requests: %0d puts, %0d reads, %0d clears, %0d unused mode.",
             n_put + n_read + n_clear + n_none, n_put, n_read, n_clear, n_none);
    $display("Checked %0d result words, %0d of them reporting a scroll.", n_results, n_scrolls);
    if (n_fail == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
